// ===== rtl/keyframe_timeline_lookup_assert.svh =====
// Assertion macros for the keyframe timeline lookup block
`ifndef KEYFRAME_TIMELINE_LOOKUP_ASSERT_SVH
`define KEYFRAME_TIMELINE_LOOKUP_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define KTL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset
`define KTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/ktl_pkg.sv =====
// ----------------------------------------------------------------------------
// ktl_pkg
// Shared types and constants of the keyframe timeline lookup block.
// ----------------------------------------------------------------------------
`default_nettype none
package ktl_pkg;
   localparam int MAX_ENTRIES_DEF = 64;

   localparam logic [2:0] FUNC_APPEND   = 3'd0;
   localparam logic [2:0] FUNC_CLEAR    = 3'd1;
   localparam logic [2:0] FUNC_REMOVE   = 3'd2;
   localparam logic [2:0] FUNC_LOOKUP   = 3'd3;
   localparam logic [2:0] FUNC_PLAYBACK = 3'd4;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_FULL  = 3'd2;
   localparam logic [2:0] ST_RANGE = 3'd3;
   localparam logic [2:0] ST_DIV0  = 3'd4;

   localparam logic [23:0] FACTOR_MAX = 24'hFFFFFF;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_SHIFT_RD, S_SHIFT_WR, S_SCAN_RD, S_SCAN_EV,
      S_END_RD, S_END_EV, S_DIV, S_DONE
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;       // capture request
      logic do_append;
      logic do_clear;
      logic rm_begin;   // subtract removed duration, set index
      logic shift_rd;
      logic shift_wr;   // write index, advance
      logic rm_finish;  // decrement count
      logic scan_init;
      logic scan_rd;
      logic scan_step;
      logic end_rd;
      logic end_eval;
      logic div_step;
      logic finish;     // drive result
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic [2:0] func;
      logic       empty;
      logic       full;
      logic       pos_bad;
      logic       shift_last;
      logic       scan_last;
      logic       scan_stop;
      logic       end_bad;
      logic       div_zero;
      logic       div_last;
   } stat_type;
endpackage
`default_nettype wire

// ===== rtl/ktl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ktl_ctrl
// Sequencer that steps the datapath through each command.
// ----------------------------------------------------------------------------
`default_nettype none
module ktl_ctrl
   import ktl_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start_ok,
   input  wire stat_type stat,
   output cmd_type       cmd,
   output logic          busy
);
   state_type state_ff, state_in;

   // advance state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (start_ok) state_in = S_DISPATCH;
         S_DISPATCH: begin
            state_in = S_DONE;
            if (stat.func == FUNC_REMOVE && !stat.empty && !stat.pos_bad)
               state_in = S_SHIFT_RD;
            else if ((stat.func == FUNC_LOOKUP && !stat.empty) ||
                     (stat.func == FUNC_PLAYBACK && !stat.empty && !stat.pos_bad))
               state_in = S_SCAN_RD;
         end
         S_SHIFT_RD: state_in = stat.shift_last ? S_DONE : S_SHIFT_WR;
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_SCAN_RD:  state_in = S_SCAN_EV;
         S_SCAN_EV: begin
            if (stat.scan_stop || stat.scan_last)
               state_in = (stat.func == FUNC_LOOKUP) ? S_END_RD : S_DONE;
            else state_in = S_SCAN_RD;
         end
         S_END_RD:   state_in = stat.end_bad ? S_DONE : S_END_EV;
         S_END_EV:   state_in = stat.div_zero ? S_DONE : S_DIV;
         S_DIV:      if (stat.div_last) state_in = S_DONE;
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      busy = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE:     cmd.load = start_ok;
         S_DISPATCH: begin
            cmd.do_append = (stat.func == FUNC_APPEND) && !stat.full;
            cmd.do_clear  = (stat.func == FUNC_CLEAR);
            cmd.rm_begin  = (stat.func == FUNC_REMOVE) && !stat.empty && !stat.pos_bad;
            cmd.scan_init = 1'b1;
         end
         S_SHIFT_RD: begin
            cmd.shift_rd  = !stat.shift_last;
            cmd.rm_finish = stat.shift_last;
         end
         S_SHIFT_WR: cmd.shift_wr = 1'b1;
         S_SCAN_RD:  cmd.scan_rd = 1'b1;
         S_SCAN_EV:  cmd.scan_step = 1'b1;
         S_END_RD:   cmd.end_rd = 1'b1;
         S_END_EV:   cmd.end_eval = 1'b1;
         S_DIV:      cmd.div_step = 1'b1;
         S_DONE:     cmd.finish = 1'b1;
         default:    cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/ktl_datapath.sv =====
// ----------------------------------------------------------------------------
// ktl_datapath
// Entry memory, running totals, scan accumulator and serial divider.
// ----------------------------------------------------------------------------
`default_nettype none
module ktl_datapath
   import ktl_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [2:0]  req_func,
   input  wire logic [15:0] req_keyframe_id,
   input  wire logic [31:0] req_duration,
   input  wire logic [5:0]  req_position,
   input  wire logic [31:0] req_query_time,
   input  wire logic        req_loop_enable,
   input  wire logic [5:0]  req_loop_position,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_start_keyframe,
   output logic [15:0]      rsp_end_keyframe,
   output logic [23:0]      rsp_blend_factor,
   output logic [37:0]      rsp_playback_time,
   output logic [37:0]      rsp_total_time,
   output logic [6:0]       rsp_entry_count
);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   // entry memory: id and duration packed
   logic [47:0] mem [MAX_ENTRIES];
   logic [47:0] rd_ff;

   // captured request
   logic [2:0]  func_ff;
   logic [15:0] kid_ff;
   logic [31:0] dur_ff;
   logic [5:0]  pos_ff;
   logic [31:0] qt_ff;
   logic        loop_ff;
   logic [5:0]  lpos_ff;

   logic [CW-1:0] count_ff;
   logic [37:0]   sum_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [AW-1:0] s_ff;
   logic [15:0]   skey_ff;
   logic [38:0]   acc_ff;   // cumulative time
   logic [38:0]   start_t_ff;
   logic [2:0]    status_ff;
   logic [15:0]   ekey_ff;
   logic [31:0]   div_d_ff;
   logic [47:0]   div_q_ff;
   logic [32:0]   div_r_ff;
   logic [5:0]    div_n_ff;

   // removed entry duration: read from memory at the requested position when the request is loaded
   logic [31:0] mem_dur_pos;
   logic [31:0] rm_dur_ff;

   logic [CW-1:0] pos_x, lpos_x, e_idx;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [47:0]   wr_data;
   logic [38:0]   nt;
   logic          at_last;

   assign mem_dur_pos = rm_dur_ff;
   assign pos_x  = CW'(pos_ff);
   assign lpos_x = CW'(lpos_ff);
   assign nt     = acc_ff + ((idx_ff == '0) ? 39'd0 : 39'(rd_ff[31:0]));
   assign at_last = (CW'(s_ff) == count_ff - CW'(1));
   assign e_idx  = at_last ? (loop_ff ? lpos_x : CW'(s_ff)) : CW'(s_ff) + CW'(1);

   // status to controller
   always_comb begin
      stat.func       = func_ff;
      stat.empty      = (count_ff == '0);
      stat.full       = (count_ff >= CW'(MAX_ENTRIES));
      stat.pos_bad    = (pos_x >= count_ff) || (32'(pos_ff) >= 32'(MAX_ENTRIES));
      stat.shift_last = (idx_ff + CW'(1) >= count_ff);
      stat.scan_last  = (func_ff == FUNC_LOOKUP) ? (idx_ff + CW'(1) >= count_ff)
                                                 : (idx_ff >= pos_x);
      stat.scan_stop  = (func_ff == FUNC_LOOKUP) && (nt > 39'(qt_ff));
      stat.end_bad    = (e_idx >= count_ff) ||
                        (at_last && loop_ff && (32'(lpos_ff) >= 32'(MAX_ENTRIES)));
      stat.div_zero   = (rd_ff[31:0] == 32'd0);
      stat.div_last   = (div_n_ff == 6'd47);
   end

   // memory address selection
   always_comb begin
      rd_addr = AW'(idx_ff);
      if (cmd.shift_rd) rd_addr = AW'(idx_ff + CW'(1));
      if (cmd.scan_rd)  rd_addr = AW'(idx_ff);
      if (cmd.end_rd)   rd_addr = AW'(e_idx);
      wr_en   = cmd.do_append || cmd.shift_wr;
      wr_addr = cmd.do_append ? AW'(count_ff) : AW'(idx_ff);
      wr_data = cmd.do_append ? {kid_ff, dur_ff} : rd_ff;
   end

   // memory port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   // index register
   always_comb begin
      idx_in = idx_ff;
      if (cmd.scan_init) idx_in = '0;
      if (cmd.rm_begin)  idx_in = pos_x;
      if (cmd.shift_wr)  idx_in = idx_ff + CW'(1);
      if (cmd.scan_step) idx_in = idx_ff + CW'(1);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.finish;
         if (cmd.do_append) begin
            count_ff <= count_ff + CW'(1);
            sum_ff   <= sum_ff + 38'(dur_ff);
         end
         if (cmd.do_clear) begin
            count_ff <= '0;
            sum_ff   <= '0;
         end
         if (cmd.rm_finish) count_ff <= count_ff - CW'(1);
         if (cmd.rm_begin)  sum_ff <= sum_ff - 38'(mem_dur_pos);
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.load) begin
         func_ff <= req_func;
         kid_ff  <= req_keyframe_id;
         dur_ff  <= req_duration;
         pos_ff  <= req_position;
         qt_ff   <= req_query_time;
         loop_ff <= req_loop_enable;
         lpos_ff <= req_loop_position;
         rm_dur_ff <= mem[AW'(req_position)][31:0];
      end
      if (cmd.scan_init) begin
         acc_ff     <= '0;
         start_t_ff <= '0;
         s_ff       <= '0;
         status_ff  <= ST_OK;
         skey_ff    <= '0;
         ekey_ff    <= '0;
         div_q_ff   <= '0;
         if (func_ff == FUNC_APPEND && stat.full) status_ff <= ST_FULL;
         if ((func_ff == FUNC_REMOVE || func_ff == FUNC_PLAYBACK ||
              func_ff == FUNC_LOOKUP) && stat.empty) status_ff <= ST_EMPTY;
         else if ((func_ff == FUNC_REMOVE || func_ff == FUNC_PLAYBACK) && stat.pos_bad)
            status_ff <= ST_RANGE;
      end
      // scan: accumulate cumulative time
      if (cmd.scan_step) begin
         if (func_ff == FUNC_LOOKUP) begin
            if (!stat.scan_stop) begin
               acc_ff     <= nt;
               start_t_ff <= nt;
               s_ff       <= AW'(idx_ff);
               skey_ff    <= rd_ff[47:32];
            end
         end else begin
            acc_ff <= acc_ff + 39'(rd_ff[31:0]);
         end
      end
      // end entry checks
      if (cmd.end_rd && stat.end_bad) begin
         status_ff <= ST_RANGE;
         skey_ff   <= '0;
      end
      if (cmd.end_eval) begin
         ekey_ff  <= rd_ff[47:32];
         div_d_ff <= rd_ff[31:0];
         div_r_ff <= '0;
         div_n_ff <= '0;
         div_q_ff <= {qt_ff - start_t_ff[31:0], 16'd0};
         if (stat.div_zero) status_ff <= ST_DIV0;
      end
      // restoring division, one quotient bit per cycle
      if (cmd.div_step) begin
         if ({div_r_ff[31:0], div_q_ff[47]} >= {1'b0, div_d_ff}) begin
            div_r_ff <= {div_r_ff[31:0], div_q_ff[47]} - {1'b0, div_d_ff};
            div_q_ff <= {div_q_ff[46:0], 1'b1};
         end else begin
            div_r_ff <= {div_r_ff[31:0], div_q_ff[47]};
            div_q_ff <= {div_q_ff[46:0], 1'b0};
         end
         div_n_ff <= div_n_ff + 6'd1;
      end
      // result
      if (cmd.finish) begin
         rsp_status         <= status_ff;
         rsp_start_keyframe <= '0;
         rsp_end_keyframe   <= '0;
         rsp_blend_factor   <= '0;
         rsp_playback_time  <= '0;
         rsp_total_time     <= sum_ff;
         rsp_entry_count    <= 7'(count_ff);
         if (func_ff == FUNC_LOOKUP && (status_ff == ST_OK || status_ff == ST_DIV0)) begin
            rsp_start_keyframe <= skey_ff;
            rsp_end_keyframe   <= ekey_ff;
            if (status_ff == ST_OK)
               rsp_blend_factor <= (div_q_ff[47:24] != '0) ? FACTOR_MAX : div_q_ff[23:0];
         end
         if (func_ff == FUNC_PLAYBACK && status_ff == ST_OK)
            rsp_playback_time <= acc_ff[37:0];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/keyframe_timeline_lookup.sv =====
// ----------------------------------------------------------------------------
// keyframe_timeline_lookup
// Ordered keyframe table with time lookup and serial blend-factor division.
// ----------------------------------------------------------------------------
// Usage: raise start with a command word on the req_ ports while busy is low;
// the word is taken at that edge and busy rises in the next cycle. One result
// word appears on the rsp_ ports for one cycle, marked by rsp_valid.
// The receiver cannot stall; each result must be taken when shown.
// Work per command, with N entries held and position P:
//   append, clear, unused codes and errors found at dispatch: straight to result
//   remove: the N-1-P later entries are shifted down, one read and one write each
//   playback time: P+1 entries summed, one memory read per summed entry
//   lookup: a scan of the entries, the end entry read, then the serial divider
// The registered memory read paces the scan and shift, and the
// restoring divider gives one quotient bit per cycle.
// Items are taken one at a time; start is ignored while busy.
// Reset empties the table and zeroes the total; entry contents stay
// undefined until appended.
// ----------------------------------------------------------------------------
`default_nettype none
module keyframe_timeline_lookup
   import ktl_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_func,
   input  wire logic [15:0] req_keyframe_id,
   input  wire logic [31:0] req_duration,
   input  wire logic [5:0]  req_position,
   input  wire logic [31:0] req_query_time,
   input  wire logic        req_loop_enable,
   input  wire logic [5:0]  req_loop_position,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_start_keyframe,
   output logic [15:0]      rsp_end_keyframe,
   output logic [23:0]      rsp_blend_factor,
   output logic [37:0]      rsp_playback_time,
   output logic [37:0]      rsp_total_time,
   output logic [6:0]       rsp_entry_count
);
`include "keyframe_timeline_lookup_assert.svh"
   cmd_type  cmd;
   stat_type stat;
   logic     start_ok;

   assign start_ok = start && !busy;

   ktl_ctrl u_ctrl (
      .clock, .reset, .start_ok, .stat, .cmd, .busy
   );

   ktl_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock, .reset, .cmd, .stat,
      .req_func, .req_keyframe_id, .req_duration, .req_position,
      .req_query_time, .req_loop_enable, .req_loop_position,
      .rsp_valid, .rsp_status, .rsp_start_keyframe, .rsp_end_keyframe,
      .rsp_blend_factor, .rsp_playback_time, .rsp_total_time, .rsp_entry_count
   );

   `KTL_ASSERT_NEXT(a_busy_after_start, clock, reset, start_ok, busy, "busy not raised")
   `KTL_ASSERT_IMPL(a_count_bound, clock, reset, rsp_valid, 32'(rsp_entry_count) <= 32'(MAX_ENTRIES), "count too large")
   `KTL_ASSERT_NEXT(a_valid_ends, clock, reset, rsp_valid, !rsp_valid, "result shown twice")
endmodule
`default_nettype wire
